// ----- rtl/core/ffba_pkg.sv -----
// Shared constants and types for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 24;
	localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W       = 32;
	localparam int SIZE_W       = 24;
	localparam int CFG_IDX_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = CFG_IDX_W'(1);

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_ZERO_SIZE   = 3'd1;
	localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
	localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_PTR = 3'd5;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_addr;
		logic [2:0]        status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} tbl_entry_t;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_table.sv -----
// Block table storage: base and size per block, one write port, one registered read port.
`default_nettype none
module ffba_table (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ffba_pkg::IDX_W-1:0]  wr_addr,
	input  wire ffba_pkg::tbl_entry_t        wr_entry,
	input  wire logic [ffba_pkg::IDX_W-1:0]  rd_addr,
	output ffba_pkg::tbl_entry_t             rd_entry
);

	ffba_pkg::tbl_entry_t mem_q [ffba_pkg::MAX_BLOCKS];
	ffba_pkg::tbl_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_entry = rd_q;

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_unit.sv -----
// First-fit block allocator: request sequencer, table scan and heap top bookkeeping.
// Zero-size allocations finish without a scan; other requests scan the table one entry
// per cycle through the table read port, and an append then passes through the append
// and check states. The worst case is an append after 63 entries have been scanned.
// One request at a time; the next is taken once the previous result is registered.
// Reset clears the block count, free marks and heap top (to 0); no clearing pass.
`default_nettype none
module first_fit_block_allocator_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire ffba_pkg::req_t                  req_data,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output ffba_pkg::rsp_t                       rsp_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	localparam logic [31:0] HDR32 = 32'(ffba_pkg::HEADER_BYTES);

	logic [2:0]                      state_q;
	ffba_pkg::req_t                  req_q;
	logic [31:0]                     target_q;
	logic [31:0]                     base_q;
	logic [31:0]                     limit_q;
	logic [31:0]                     top_q;
	logic [32:0]                     new_top_q;
	logic [ffba_pkg::CNT_W-1:0]      cnt_q;
	logic [ffba_pkg::CNT_W-1:0]      scan_q;
	logic [ffba_pkg::MAX_BLOCKS-1:0] free_q;
	logic                            chk_s1;
	logic [ffba_pkg::IDX_W-1:0]      cmp_idx_s1;
	logic [31:0]                     res_addr_q;
	logic [2:0]                      res_status_q;
	logic                            rsp_valid_q;
	ffba_pkg::rsp_t                  rsp_q;

	logic                            req_xfer;
	logic                            cfg_xfer;
	logic                            issue;
	logic                            hit;
	logic                            scan_end;
	logic                            cur_free;
	logic                            over;
	logic                            tbl_wr;
	logic                            rsp_load;
	ffba_pkg::tbl_entry_t            tbl_wr_entry;
	ffba_pkg::tbl_entry_t            tbl_rd_entry;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	assign issue    = (state_q == S_SCAN) && (scan_q < cnt_q);
	assign cur_free = free_q[cmp_idx_s1];
	assign hit      = chk_s1 && ((req_q.req_type == ffba_pkg::REQ_FREE)
		? (tbl_rd_entry.base == target_q)
		: (cur_free && (tbl_rd_entry.size >= req_q.req_size)));
	assign scan_end = !hit && (scan_q == cnt_q);
	assign over     = new_top_q[32] || ((new_top_q[31:0] - 32'd1) > limit_q);
	assign tbl_wr   = (state_q == S_CHECK) && !over;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	assign tbl_wr_entry.base = top_q;
	assign tbl_wr_entry.size = req_q.req_size;

	ffba_table u_table (
		.clk      (clk),
		.wr_en    (tbl_wr),
		.wr_addr  (cnt_q[ffba_pkg::IDX_W-1:0]),
		.wr_entry (tbl_wr_entry),
		.rd_addr  (scan_q[ffba_pkg::IDX_W-1:0]),
		.rd_entry (tbl_rd_entry)
	);

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q    <= req_data;
			target_q <= req_data.free_addr - HDR32;
		end
		if (state_q == S_APPEND) begin
			new_top_q <= {1'b0, top_q} + {1'b0, HDR32} + 33'(req_q.req_size);
		end
		if (issue) begin
			cmp_idx_s1 <= scan_q[ffba_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			limit_q      <= '1;
			top_q        <= '0;
			cnt_q        <= '0;
			scan_q       <= '0;
			free_q       <= '0;
			chk_s1       <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= ffba_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_xfer) begin
				if (cfg_index == ffba_pkg::REG_HEAP_BASE) begin
					base_q <= cfg_data;
					if (cnt_q == '0) begin
						top_q <= cfg_data;
					end
				end else if (cfg_index == ffba_pkg::REG_HEAP_LIMIT) begin
					limit_q <= cfg_data;
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			chk_s1 <= issue && !hit;
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					scan_q     <= '0;
					res_addr_q <= '0;
					if (req_xfer) begin
						if (req_data.req_type == ffba_pkg::REQ_ALLOC && req_data.req_size == '0) begin
							res_status_q <= ffba_pkg::ST_ZERO_SIZE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (req_q.req_type == ffba_pkg::REQ_FREE) begin
							if (cur_free) begin
								res_status_q <= ffba_pkg::ST_DOUBLE_FREE;
							end else begin
								free_q[cmp_idx_s1] <= 1'b1;
								res_status_q       <= ffba_pkg::ST_OK;
							end
						end else begin
							free_q[cmp_idx_s1] <= 1'b0;
							res_addr_q         <= tbl_rd_entry.base + HDR32;
							res_status_q       <= ffba_pkg::ST_OK;
						end
						state_q <= S_DONE;
					end else if (scan_end) begin
						if (req_q.req_type == ffba_pkg::REQ_FREE) begin
							res_status_q <= (req_q.free_addr == '0) ? ffba_pkg::ST_OK
								: ffba_pkg::ST_UNKNOWN_PTR;
							state_q <= S_DONE;
						end else if (cnt_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) begin
							res_status_q <= ffba_pkg::ST_TABLE_FULL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_APPEND: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (over) begin
						res_status_q <= ffba_pkg::ST_NO_MEMORY;
					end else begin
						free_q[cnt_q[ffba_pkg::IDX_W-1:0]] <= 1'b0;
						res_addr_q   <= top_q + HDR32;
						res_status_q <= ffba_pkg::ST_OK;
						cnt_q        <= cnt_q + 1'b1;
						top_q        <= new_top_q[31:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.result_addr <= res_addr_q;
						rsp_q.status      <= res_status_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// table never grows past its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
		else $error("block count overflow");

	// a new result appears only out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result without completion");

	// table read data is checked only during a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> state_q == S_SCAN)
		else $error("compare outside scan");

	// count only steps up by one, from a successful append
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> ($past(state_q) == S_CHECK) && (cnt_q == $past(cnt_q) + 1'b1))
		else $error("unexpected block count change");

	// heap top never moves back once blocks exist
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && ($past(cnt_q) != '0) |-> top_q >= $past(top_q))
		else $error("heap top moved back");

endmodule
`default_nettype wire
